/* sv/evh_pkg.sv */
// Shared types, constants and codes for the energy voice activity detector.
package evh_pkg;

    localparam int MAX_FRAME_SAMPLES = 480;

    localparam int SAMPLE_W    = 16;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int ENERGY_W    = 40;
    localparam int SAMPLES_W   = 9;
    localparam int THR_W       = 16;
    localparam int DUR_W       = 10;
    localparam int HANG_W      = 16;
    localparam int SIL_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_W       = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int LIMIT_W     = SQ_W + CNT_W;
    localparam int CMP_W       = (LIMIT_W > ENERGY_W) ? LIMIT_W : ENERGY_W;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [SIL_W-1:0]    SILENCE_MAX = {SIL_W{1'b1}};

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(500);
    localparam logic [DUR_W-1:0]  DUR_RESET  = DUR_W'(30);
    localparam logic [HANG_W-1:0] HANG_RESET = HANG_W'(1500);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RMS_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_DURATION_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HANGOVER_MS       = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_VOICED   = 2'd0,
        VERDICT_HANGOVER = 2'd1,
        VERDICT_END      = 2'd2,
        VERDICT_IDLE     = 2'd3
    } verdict_t;

    // closed frame handed from front to back
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [LIMIT_W-1:0]  limit;
        logic [CNT_W-1:0]    count;
    } frame_t;

    // hangover settings seen by the back end
    typedef struct packed {
        logic [DUR_W-1:0]  dur;
        logic [HANG_W-1:0] hangover;
    } hang_cfg_t;

endpackage

/* sv/evh_front.sv */
// Front end: squares samples, accumulates energy and count, closes frames with their limit.
module evh_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [evh_pkg::SAMPLE_W-1:0] sample,
    input  logic                          last_sample,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [evh_pkg::SQ_W-1:0]      thr_sq,
    input  logic                          q_full,
    output logic                          q_push,
    output evh_pkg::frame_t               q_data
);
    import evh_pkg::*;

    logic                a_valid_reg, a_valid_next;
    logic [SQ_W-1:0]     a_sq_reg;
    logic                a_last_reg;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic [SAMPLE_W-1:0] mag;
    logic [SQ_W-1:0]     sq;
    logic                in_accept;
    logic                a_closes;
    logic                a_fire;
    logic                a_load;
    logic [ENERGY_W:0]   energy_sum;
    logic [ENERGY_W-1:0] energy_sat;
    logic [LIMIT_W-1:0]  limit;
    logic [CNT_W-1:0]    count_inc;

    // -32768 maps to 0x8000, which is correct as an unsigned magnitude
    assign mag = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
    assign sq  = SQ_W'(mag) * SQ_W'(mag);

    assign a_closes  = a_last_reg || (count_reg >= CNT_W'(MAX_FRAME_SAMPLES - 1));
    assign a_fire    = a_valid_reg && !(a_closes && q_full);
    assign in_stall  = a_valid_reg && !a_fire;
    assign in_accept = in_valid && !in_stall;
    assign a_load    = a_fire || !a_valid_reg;

    assign energy_sum = {1'b0, energy_reg} + (ENERGY_W + 1)'(a_sq_reg);
    assign energy_sat = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
    assign count_inc  = count_reg + CNT_W'(1);

    // threshold squared times count, taken with the threshold in force at frame end
    assign limit = LIMIT_W'(thr_sq) * LIMIT_W'(count_inc);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_load)
        begin
            a_valid_next = in_accept;
        end
        energy_next = energy_reg;
        count_next  = count_reg;
        if (a_fire)
        begin
            if (a_closes)
            begin
                energy_next = '0;
                count_next  = '0;
            end
            else
            begin
                energy_next = energy_sat;
                count_next  = count_inc;
            end
        end
    end

    assign q_push        = a_fire && a_closes;
    assign q_data.energy = energy_sat;
    assign q_data.limit  = limit;
    assign q_data.count  = count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            energy_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            energy_reg  <= energy_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_sq_reg   <= sq;
            a_last_reg <= last_sample;
        end
    end

endmodule

/* sv/evh_fifo.sv */
// Short queue of closed frame records between front and back.
module evh_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  evh_pkg::frame_t wr_data,
    input  logic            pop,
    output evh_pkg::frame_t rd_data,
    output logic            full,
    output logic            empty
);
    import evh_pkg::*;

    frame_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;

    assign full    = (fill_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/evh_back.sv */
// Back end: voicing test, hangover tracking and the output register.
module evh_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  evh_pkg::frame_t                q_data,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  evh_pkg::hang_cfg_t             cfg,
    output logic [1:0]                     verdict,
    output logic                           voice_started,
    output logic [evh_pkg::ENERGY_W-1:0]   frame_energy,
    output logic [evh_pkg::SAMPLES_W-1:0]  frame_samples,
    output logic                           out_valid,
    input  logic                           out_stall
);
    import evh_pkg::*;

    logic                 out_valid_reg, out_valid_next;
    verdict_t             verdict_reg, verdict_next;
    logic                 started_reg, started_next;
    logic [ENERGY_W-1:0]  energy_reg;
    logic [SAMPLES_W-1:0] samples_reg;
    logic                 active_reg, active_next;
    logic [SIL_W-1:0]     silence_reg, silence_next;

    logic                 voiced;
    logic [SIL_W:0]       silence_sum;
    logic [SIL_W-1:0]     silence_sat;

    assign q_pop  = !q_empty && (!out_valid_reg || !out_stall);
    assign voiced = CMP_W'(q_data.energy) > CMP_W'(q_data.limit);

    assign silence_sum = {1'b0, silence_reg} + (SIL_W + 1)'(cfg.dur);
    assign silence_sat = silence_sum[SIL_W] ? SILENCE_MAX : silence_sum[SIL_W-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        verdict_next   = verdict_reg;
        started_next   = started_reg;
        active_next    = active_reg;
        silence_next   = silence_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
            started_next   = 1'b0;
            if (voiced)
            begin
                verdict_next = VERDICT_VOICED;
                started_next = !active_reg;
                active_next  = 1'b1;
                silence_next = '0;
            end
            else if (active_reg)
            begin
                silence_next = silence_sat;
                if (silence_sat > cfg.hangover)
                begin
                    verdict_next = VERDICT_END;
                    active_next  = 1'b0;
                end
                else
                begin
                    verdict_next = VERDICT_HANGOVER;
                end
            end
            else
            begin
                verdict_next = VERDICT_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            silence_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            silence_reg   <= silence_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        started_reg <= started_next;
        if (q_pop)
        begin
            energy_reg  <= q_data.energy;
            samples_reg <= SAMPLES_W'(q_data.count);
        end
    end

    assign out_valid     = out_valid_reg;
    assign verdict       = verdict_reg;
    assign voice_started = started_reg;
    assign frame_energy  = energy_reg;
    assign frame_samples = samples_reg;

endmodule

/* sv/energy_vad_hangover.sv */
// Top level: configuration registers, front end, frame queue and back end.
// The closing sample passes the square register and the frame queue before the result word is registered.
// Throughput: one sample per cycle while in_stall is low; the square stage and the accumulator are registered.
// The front stalls only when a frame closes with the four-entry frame queue full.
// Reset (async, active low) clears pipeline, queue and detector state and loads register defaults.
module energy_vad_hangover (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [evh_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_sample,
    input  logic                                in_valid,
    output logic                                in_stall,
    output logic [1:0]                          verdict,
    output logic                                voice_started,
    output logic [evh_pkg::ENERGY_W-1:0]        frame_energy,
    output logic [evh_pkg::SAMPLES_W-1:0]       frame_samples,
    output logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                cfg_wr_en,
    input  logic [evh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [evh_pkg::CFG_W-1:0]           cfg_data
);
    import evh_pkg::*;

    logic [THR_W-1:0]  thr_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [HANG_W-1:0] hang_reg;
    logic [SQ_W-1:0]   thr_sq_reg, thr_sq_next;

    logic      q_push, q_pop, q_full, q_empty;
    frame_t    q_wr_data, q_rd_data;
    hang_cfg_t hang_cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            dur_reg  <= DUR_RESET;
            hang_reg <= HANG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RMS_THRESHOLD:     thr_reg  <= THR_W'(cfg_data);
                REG_FRAME_DURATION_MS: dur_reg  <= DUR_W'(cfg_data);
                REG_HANGOVER_MS:       hang_reg <= HANG_W'(cfg_data);
                default:               ;
            endcase
        end
    end

    // threshold squared, settles in the cycle after a write
    assign thr_sq_next = SQ_W'(thr_reg) * SQ_W'(thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_sq_reg <= SQ_W'(THR_RESET) * SQ_W'(THR_RESET);
        end
        else
        begin
            thr_sq_reg <= thr_sq_next;
        end
    end

    assign hang_cfg.dur      = dur_reg;
    assign hang_cfg.hangover = hang_reg;

    evh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .last_sample (last_sample),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .thr_sq      (thr_sq_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wr_data)
    );

    evh_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    evh_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_rd_data),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .cfg           (hang_cfg),
        .verdict       (verdict),
        .voice_started (voice_started),
        .frame_energy  (frame_energy),
        .frame_samples (frame_samples),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("frame pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("frame popped from empty queue");

    a_started_voiced: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && voice_started) |-> (verdict == VERDICT_VOICED))
        else $error("voice start on a non-voiced word");

    a_stall_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full)
        else $error("input stalled with room in queue");

endmodule

/* tb/energy_vad_hangover_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the energy voice activity detector with hangover.
module energy_vad_hangover_tb;

    import evh_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_WAIT  = 16;

    typedef struct {
        verdict_t              verdict;
        logic                  started;
        logic [ENERGY_W-1:0]   energy;
        logic [SAMPLES_W-1:0]  samples;
    } frame_result_t;

    typedef enum {KIND_LOUD, KIND_QUIET, KIND_AT_LIMIT, KIND_NOISE} frame_kind_t;
    typedef enum {EXTRA_NONE, EXTRA_FORCED_CLOSE, EXTRA_FULL_FRAME, EXTRA_LONG_SILENCE} extra_t;

    // Frame-level predictor plus the queue of frame verdicts still owed by the block.
    class vad_scoreboard;
        logic [THR_W-1:0]  thr;
        logic [DUR_W-1:0]  dur;
        logic [HANG_W-1:0] hang;
        longint unsigned   energy_acc;
        int unsigned       sample_cnt;
        bit                active;
        int unsigned       silence;
        frame_result_t     frames_due[$];
        int                errors;
        int                samples_in;
        int                frames_seen;
        int                starts_seen;
        int                silence_sat;
        int                verdicts_seen[4];

        function new();
            thr = THR_RESET;
            dur = DUR_RESET;
            hang = HANG_RESET;
            energy_acc = 0;
            sample_cnt = 0;
            active = 1'b0;
            silence = 0;
            errors = 0;
            samples_in = 0;
            frames_seen = 0;
            starts_seen = 0;
            silence_sat = 0;
            foreach (verdicts_seen[i])
                verdicts_seen[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_RMS_THRESHOLD:     thr = data[THR_W-1:0];
                REG_FRAME_DURATION_MS: dur = data[DUR_W-1:0];
                REG_HANGOVER_MS:       hang = data[HANG_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] s, logic mark);
            longint          sv;
            longint unsigned t64;
            longint unsigned lim;
            frame_result_t   r;
            sv = s;
            samples_in++;
            energy_acc += longint'(sv * sv);
            if (energy_acc > ENERGY_MAX)
                energy_acc = ENERGY_MAX;
            sample_cnt++;
            if (!mark && sample_cnt < MAX_FRAME_SAMPLES)
                return;
            t64 = thr;
            lim = t64 * t64 * sample_cnt;
            r.started = 1'b0;
            if (energy_acc > lim)
            begin
                r.started = !active;
                active = 1'b1;
                silence = 0;
                r.verdict = VERDICT_VOICED;
            end
            else if (active)
            begin
                silence += dur;
                if (silence > SILENCE_MAX)
                begin
                    silence = SILENCE_MAX;
                    silence_sat++;
                end
                if (silence > hang)
                begin
                    active = 1'b0;
                    r.verdict = VERDICT_END;
                end
                else
                    r.verdict = VERDICT_HANGOVER;
            end
            else
                r.verdict = VERDICT_IDLE;
            r.energy = energy_acc[ENERGY_W-1:0];
            r.samples = sample_cnt[SAMPLES_W-1:0];
            energy_acc = 0;
            sample_cnt = 0;
            frames_due.push_back(r);
        endfunction

        function void mismatch(string what, logic [63:0] want, logic [63:0] got);
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        endfunction

        function void check_frame(logic [1:0] v, logic st, logic [ENERGY_W-1:0] e,
                                  logic [SAMPLES_W-1:0] n);
            frame_result_t r;
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected word, verdict %0d energy %0d samples %0d",
                         $time, v, e, n);
                errors++;
                return;
            end
            r = frames_due.pop_front();
            frames_seen++;
            verdicts_seen[r.verdict]++;
            if (r.started)
                starts_seen++;
            if (v !== r.verdict)
                mismatch("verdict", r.verdict, v);
            if (st !== r.started)
                mismatch("voice_started", r.started, st);
            if (e !== r.energy)
                mismatch("frame_energy", r.energy, e);
            if (n !== r.samples)
                mismatch("frame_samples", r.samples, n);
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic signed [SAMPLE_W-1:0]    sample;
    logic                          last_sample;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    verdict;
    logic                          voice_started;
    logic [ENERGY_W-1:0]           frame_energy;
    logic [SAMPLES_W-1:0]          frame_samples;
    logic                          out_valid;
    logic                          out_stall;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]              cfg_data;

    vad_scoreboard sb;
    int            in_calm;
    int            cycles;
    int            settings_run;

    energy_vad_hangover dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample),
        .last_sample   (last_sample),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .verdict       (verdict),
        .voice_started (voice_started),
        .frame_energy  (frame_energy),
        .frame_samples (frame_samples),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(frame_kind_t kind,
                                                               int unsigned thr);
        int unsigned mag;
        bit          neg;
        int          v;
        neg = 1'($urandom_range(0, 1));
        case (kind)
            KIND_LOUD:     mag = (thr >= 32768) ? $urandom_range(0, 32768)
                                                : $urandom_range(thr + 1, 32768);
            KIND_QUIET:    mag = $urandom_range(0, (thr > 32768) ? 32768 : thr);
            KIND_AT_LIMIT: mag = (thr > 32768) ? 32768 : thr;
            default:       return SAMPLE_W'($urandom);
        endcase
        if (mag == 32768)
            neg = 1'b1;
        v = neg ? -int'(mag) : int'(mag);
        return SAMPLE_W'(v);
    endfunction

    function automatic int frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 97)
            return $urandom_range(9, 40);
        return $urandom_range(41, 100);
    endfunction

    function automatic frame_kind_t quiet_kind();
        return ($urandom_range(0, 3) == 0) ? KIND_AT_LIMIT : KIND_QUIET;
    endfunction

    task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic mark);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            sample = SAMPLE_W'($urandom);
            last_sample = 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        sample = s;
        last_sample = mark;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(s, mark);
    endtask

    // close_mark 0 leaves the frame to be closed by the length limit
    task automatic send_frame(frame_kind_t kind, int len, bit close_mark);
        logic mark;
        for (int i = 0; i < len; i++)
        begin
            mark = (kind == KIND_NOISE) ? ($urandom_range(0, 7) == 0) : 1'b0;
            if (i == len - 1)
                mark = close_mark;
            send_word(pick_sample(kind, sb.thr), mark);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.frames_due.size() != 0)
            @(posedge clk);
        // a mid-frame word may still sit in the pipeline
        repeat (6) @(posedge clk);
    endtask

    task automatic write_regs(int unsigned thr, int unsigned dur, int unsigned hang);
        logic [CFG_W-1:0] dur_word;
        dur_word = CFG_W'($urandom);
        dur_word[DUR_W-1:0] = DUR_W'(dur);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = REG_RMS_THRESHOLD;
        cfg_data = CFG_W'(thr);
        sb.write_reg(REG_RMS_THRESHOLD, CFG_W'(thr));
        @(negedge clk);
        cfg_index = REG_FRAME_DURATION_MS;
        cfg_data = dur_word;
        sb.write_reg(REG_FRAME_DURATION_MS, dur_word);
        @(negedge clk);
        cfg_index = REG_HANGOVER_MS;
        cfg_data = CFG_W'(hang);
        sb.write_reg(REG_HANGOVER_MS, CFG_W'(hang));
        @(negedge clk);
        cfg_wr_en = 1'b0;
        settings_run++;
    endtask

    task automatic run_directed();
        int smp [9] = '{0, -32768, 32767, -1, 1, -1, 500, -501, 0};
        bit mrk [9] = '{1, 0, 0, 1, 0, 1, 1, 1, 1};
        // idle, voiced start at full scale, hangover, level exactly at threshold, voiced again
        for (int i = 0; i < 9; i++)
            send_word(SAMPLE_W'(smp[i]), mrk[i]);
    endtask

    task automatic run_traffic(int quota, extra_t extra);
        int goal;
        int r;
        int n;
        goal = sb.samples_in + quota;
        case (extra)
            EXTRA_FORCED_CLOSE: send_frame(KIND_LOUD, MAX_FRAME_SAMPLES, 1'b0);
            EXTRA_FULL_FRAME:   send_frame(KIND_QUIET, MAX_FRAME_SAMPLES, 1'b1);
            EXTRA_LONG_SILENCE:
            begin
                send_frame(KIND_LOUD, 2, 1'b1);
                repeat (70) send_frame(quiet_kind(), $urandom_range(1, 4), 1'b1);
            end
            default: ;
        endcase
        while (sb.samples_in < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                // utterance: a voiced frame followed by a run of silent ones
                send_frame(KIND_LOUD, frame_len(), 1'b1);
                if ($urandom_range(0, 99) < 15)
                begin
                    n = $urandom_range(20, 80);
                    repeat (n) send_frame(quiet_kind(), $urandom_range(1, 4), 1'b1);
                end
                else
                begin
                    n = $urandom_range(0, 6);
                    repeat (n) send_frame(quiet_kind(), frame_len(), 1'b1);
                end
            end
            else if (r < 85)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_frame(quiet_kind(), frame_len(), 1'b1);
            end
            else
                send_frame(KIND_NOISE, $urandom_range(1, 30), 1'b1);
        end
    endtask

    task automatic run_setting(int unsigned thr, int unsigned dur, int unsigned hang,
                               int quota, extra_t extra);
        wait_idle();
        write_regs(thr, dur, hang);
        run_traffic(quota, extra);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_frame(verdict, voice_started, frame_energy, frame_samples);
    end

    initial
    begin
        int hold;
        int calm;
        hold = 0;
        calm = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                hold = pick_gap(calm);
                out_stall = (hold > 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    initial
    begin
        sb = new();
        in_calm = 0;
        cycles = 0;
        settings_run = 1;
        rst_n = 1'b0;
        sample = '0;
        last_sample = 1'b0;
        in_valid = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_RMS_THRESHOLD;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_traffic(120, EXTRA_NONE);
        run_setting(0, 1, 0, 500, EXTRA_FORCED_CLOSE);
        run_setting(32768, 1000, 60000, 90, EXTRA_NONE);
        run_setting(300, 1023, 65535, 90, EXTRA_LONG_SILENCE);
        run_setting(1000, 0, 100, 90, EXTRA_NONE);
        run_setting(65535, 500, 0, 90, EXTRA_NONE);
        run_setting(200, 30, 90, 500, EXTRA_FULL_FRAME);
        run_setting(12345, 7, 300, 90, EXTRA_NONE);
        run_setting($urandom_range(0, 4000), $urandom_range(0, 1023),
                    $urandom_range(0, 65535), 90, EXTRA_NONE);

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d samples over %0d register settings, %0d frames checked",
                 sb.samples_in, settings_run, sb.frames_seen);
        $display("voiced %0d (starts %0d), hangover %0d, end %0d, idle %0d, silence clamped %0d",
                 sb.verdicts_seen[VERDICT_VOICED], sb.starts_seen,
                 sb.verdicts_seen[VERDICT_HANGOVER], sb.verdicts_seen[VERDICT_END],
                 sb.verdicts_seen[VERDICT_IDLE], sb.silence_sat);
        if (sb.frames_due.size() != 0)
            $display("%0d expected words never arrived", sb.frames_due.size());
        if (sb.errors == 0 && sb.frames_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
sv/evh_pkg.sv
sv/evh_front.sv
sv/evh_fifo.sv
sv/evh_back.sv
sv/energy_vad_hangover.sv
tb/energy_vad_hangover_tb.sv
